>>> sv/stlt_pkg.sv
package stlt_pkg;

    // Default sweep length in steps.
    localparam int MAX_STEPS_DEF = 1024;

    // Field widths fixed by the interface.
    localparam int STEP_IN_W = 10;
    localparam int POS_W     = 16;
    localparam int SOUND_W   = 3;
    localparam int MISS_W    = 4;
    localparam int TICK_W    = 16;
    localparam int MINLOCK_W = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Operation codes of an input word.
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Sound codes.
    localparam logic [SOUND_W-1:0] SND_NONE     = 3'd0;
    localparam logic [SOUND_W-1:0] SND_ACQUIRED = 3'd1;
    localparam logic [SOUND_W-1:0] SND_RESTORED = 3'd2;
    localparam logic [SOUND_W-1:0] SND_CONTACT  = 3'd3;
    localparam logic [SOUND_W-1:0] SND_TARGET   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LOCK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BREAK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LASER_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACQUIRED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 3'd5;

    // Register reset values.
    localparam logic [MINLOCK_W-1:0] MIN_LOCK_RST  = 11'd8;
    localparam logic [MISS_W-1:0]    MAX_BREAK_RST = 4'd4;
    localparam logic [TICK_W-1:0]    LASER_OFF_RST = 16'd5000;
    localparam logic [TICK_W-1:0]    ACQUIRED_RST  = 16'd30000;
    localparam logic [TICK_W-1:0]    LOST_RST      = 16'd60000;
    localparam logic [POS_W-1:0]     ROTATION_RST  = 16'd0;

    localparam logic [MISS_W-1:0] MISS_MAX  = 4'd15;
    localparam logic [TICK_W-1:0] TICK_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [MINLOCK_W-1:0] min_lock_points;
        logic [MISS_W-1:0]    max_break_points;
        logic [TICK_W-1:0]    laser_off_ticks;
        logic [TICK_W-1:0]    acquired_interval_ticks;
        logic [TICK_W-1:0]    lost_interval_ticks;
        logic [POS_W-1:0]     rotation_step;
    } t_cfg;

    typedef struct packed {
        logic               aim_valid;
        logic [POS_W-1:0]   aim_position;
        logic               laser_on;
        logic [SOUND_W-1:0] sound;
        logic               locked;
    } t_result;

endpackage

>>> sv/stlt_in_if.sv
interface stlt_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [stlt_pkg::STEP_IN_W-1:0]  scan_step;
    logic                            contact;

    modport source (output valid, output op, output scan_step, output contact, input ready);
    modport sink (input valid, input op, input scan_step, input contact, output ready);
endinterface

>>> sv/stlt_out_if.sv
interface stlt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          aim_valid;
    logic [stlt_pkg::POS_W-1:0]    aim_position;
    logic                          laser_on;
    logic [stlt_pkg::SOUND_W-1:0]  sound;
    logic                          locked;

    modport source (output valid, output aim_valid, output aim_position, output laser_on,
                    output sound, output locked, input ready);
    modport sink (input valid, input aim_valid, input aim_position, input laser_on,
                  input sound, input locked, output ready);
endinterface

>>> sv/stlt_engine.sv
module stlt_engine #(
    parameter int MAX_STEPS = stlt_pkg::MAX_STEPS_DEF,
    localparam int STEP_W = $clog2(MAX_STEPS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stlt_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    input  logic                 i_op,
    input  logic [STEP_W-1:0]    i_step,
    input  logic                 i_contact,
    output stlt_pkg::t_result    o_result
);

    localparam int PROD_W = STEP_W + stlt_pkg::POS_W;
    localparam int CMP_W  = 17;

    logic                            r_lock_open, n_lock_open;
    logic [STEP_W-1:0]               r_span_start, n_span_start;
    logic [STEP_W-1:0]               r_span_end, n_span_end;
    logic [stlt_pkg::MISS_W-1:0]     r_miss, n_miss;
    logic                            r_laser, n_laser;
    logic [stlt_pkg::TICK_W-1:0]     r_off_cnt, n_off_cnt;
    logic                            r_off_pend, n_off_pend;
    logic [stlt_pkg::TICK_W-1:0]     r_lost_cnt, n_lost_cnt;
    logic                            r_lost_pend, n_lost_pend;
    logic [stlt_pkg::TICK_W-1:0]     r_since_off, n_since_off;

    logic [STEP_W-1:0]               start_v;
    logic [STEP_W-1:0]               left;
    logic [STEP_W-1:0]               size;
    logic [STEP_W-1:0]               centre;
    logic [PROD_W-1:0]               product;
    logic [stlt_pkg::MISS_W-1:0]     miss_inc;
    logic                            aim;
    logic [stlt_pkg::SOUND_W-1:0]    sound;

    // Span geometry of the current contact; start is the new one on first contact.
    always_comb begin
        start_v = r_lock_open ? r_span_start : i_step;
        left    = (start_v < i_step) ? start_v : i_step;
        size    = (start_v < i_step) ? (i_step - start_v) : (start_v - i_step);
        centre  = left + (size >> 1);
        product = PROD_W'(centre) * PROD_W'(i_cfg.rotation_step);
        miss_inc = (r_miss == stlt_pkg::MISS_MAX) ? r_miss : (r_miss + 1'b1);
    end

    // Next state and the result of the word in flight.
    always_comb begin
        n_lock_open  = r_lock_open;
        n_span_start = r_span_start;
        n_span_end   = r_span_end;
        n_miss       = r_miss;
        n_laser      = r_laser;
        n_off_cnt    = r_off_cnt;
        n_off_pend   = r_off_pend;
        n_lost_cnt   = r_lost_cnt;
        n_lost_pend  = r_lost_pend;
        n_since_off  = r_since_off;
        aim          = 1'b0;
        sound        = stlt_pkg::SND_NONE;

        if (i_valid && (i_op == stlt_pkg::OP_SCAN)) begin
            if (i_contact) begin
                n_lock_open  = 1'b1;
                n_span_start = start_v;
                n_span_end   = i_step;
                n_miss       = '0;
                if ((CMP_W'(size) + CMP_W'(1)) >= CMP_W'(i_cfg.min_lock_points)) begin
                    aim = 1'b1;
                    if (!r_laser) begin
                        sound = (r_since_off > i_cfg.acquired_interval_ticks) ?
                                stlt_pkg::SND_ACQUIRED : stlt_pkg::SND_RESTORED;
                    end
                    n_laser     = 1'b1;
                    n_off_cnt   = i_cfg.laser_off_ticks;
                    n_off_pend  = 1'b1;
                    n_lost_pend = 1'b0;
                    n_lost_cnt  = '0;
                end
            end else if (r_lock_open) begin
                if (miss_inc > i_cfg.max_break_points) begin
                    n_lock_open  = 1'b0;
                    n_span_start = '0;
                    n_span_end   = '0;
                    n_miss       = '0;
                end else begin
                    n_miss = miss_inc;
                end
            end
        end else if (i_valid) begin
            // Tick: since-off timer first, then the lost countdown, then laser-off.
            if (r_since_off != stlt_pkg::TICK_MAX) begin
                n_since_off = r_since_off + 1'b1;
            end
            if (r_lost_pend) begin
                if (r_lost_cnt <= stlt_pkg::TICK_W'(1)) begin
                    n_lost_cnt  = '0;
                    n_lost_pend = 1'b0;
                    sound       = stlt_pkg::SND_TARGET;
                end else begin
                    n_lost_cnt = r_lost_cnt - 1'b1;
                end
            end
            if (r_off_pend) begin
                if (r_off_cnt <= stlt_pkg::TICK_W'(1)) begin
                    n_off_cnt   = '0;
                    n_off_pend  = 1'b0;
                    n_laser     = 1'b0;
                    n_since_off = '0;
                    sound       = stlt_pkg::SND_CONTACT;
                    n_lost_cnt  = i_cfg.lost_interval_ticks;
                    n_lost_pend = 1'b1;
                end else begin
                    n_off_cnt = r_off_cnt - 1'b1;
                end
            end
        end
    end

    // Result word; the aim position saturates at full scale.
    always_comb begin
        o_result.aim_valid    = aim;
        o_result.aim_position = '0;
        if (aim) begin
            o_result.aim_position = (product > PROD_W'(stlt_pkg::TICK_MAX)) ?
                                    stlt_pkg::TICK_MAX : product[stlt_pkg::POS_W-1:0];
        end
        o_result.laser_on = n_laser;
        o_result.sound    = sound;
        o_result.locked   = n_lock_open;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_open  <= 1'b0;
            r_span_start <= '0;
            r_span_end   <= '0;
            r_miss       <= '0;
            r_laser      <= 1'b0;
            r_off_cnt    <= '0;
            r_off_pend   <= 1'b0;
            r_lost_cnt   <= '0;
            r_lost_pend  <= 1'b0;
            r_since_off  <= stlt_pkg::TICK_MAX;
        end else begin
            r_lock_open  <= n_lock_open;
            r_span_start <= n_span_start;
            r_span_end   <= n_span_end;
            r_miss       <= n_miss;
            r_laser      <= n_laser;
            r_off_cnt    <= n_off_cnt;
            r_off_pend   <= n_off_pend;
            r_lost_cnt   <= n_lost_cnt;
            r_lost_pend  <= n_lost_pend;
            r_since_off  <= n_since_off;
        end
    end

endmodule

>>> sv/scan_target_lock_tracker.sv
// A result word passes through the input register and then the result register.
// Throughput: one word per cycle; the engine updates its state once per word,
// and the ready chain stalls only when the output is held.
// Reset (i_rst_n low, synchronous) clears the pipeline, restores all
// configuration registers to their defaults and returns the tracker to idle.
module scan_target_lock_tracker #(
    parameter int MAX_STEPS = stlt_pkg::MAX_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [stlt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stlt_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    stlt_in_if.sink                         i_scan,
    stlt_out_if.source                      o_result
);

    localparam int STEP_W = $clog2(MAX_STEPS);
    localparam int SAT_W  = 17;

    stlt_pkg::t_cfg     r_cfg;
    stlt_pkg::t_result  eng_result;
    stlt_pkg::t_result  r_out;
    logic               r_out_valid;
    logic               r_in_valid;
    logic               r_in_op;
    logic [STEP_W-1:0]  r_in_step;
    logic               r_in_contact;
    logic               out_adv;
    logic               process;
    logic [SAT_W-1:0]   step_ext;
    logic [SAT_W-1:0]   step_sat;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_lock_points         <= stlt_pkg::MIN_LOCK_RST;
            r_cfg.max_break_points        <= stlt_pkg::MAX_BREAK_RST;
            r_cfg.laser_off_ticks         <= stlt_pkg::LASER_OFF_RST;
            r_cfg.acquired_interval_ticks <= stlt_pkg::ACQUIRED_RST;
            r_cfg.lost_interval_ticks     <= stlt_pkg::LOST_RST;
            r_cfg.rotation_step           <= stlt_pkg::ROTATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                stlt_pkg::REG_MIN_LOCK:
                    r_cfg.min_lock_points <= i_cfg_data[stlt_pkg::MINLOCK_W-1:0];
                stlt_pkg::REG_MAX_BREAK:
                    r_cfg.max_break_points <= i_cfg_data[stlt_pkg::MISS_W-1:0];
                stlt_pkg::REG_LASER_OFF: r_cfg.laser_off_ticks <= i_cfg_data;
                stlt_pkg::REG_ACQUIRED:  r_cfg.acquired_interval_ticks <= i_cfg_data;
                stlt_pkg::REG_LOST:      r_cfg.lost_interval_ticks <= i_cfg_data;
                stlt_pkg::REG_ROTATION:  r_cfg.rotation_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the input stage moves whenever the output stage can take a word.
    assign out_adv      = !r_out_valid || o_result.ready;
    assign process      = r_in_valid && out_adv;
    assign i_scan.ready = !r_in_valid || out_adv;

    // Steps past the end of the sweep clamp to the last step.
    assign step_ext = SAT_W'(i_scan.scan_step);
    assign step_sat = (step_ext >= SAT_W'(MAX_STEPS)) ? SAT_W'(MAX_STEPS - 1) : step_ext;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.ready) begin
            r_in_op      <= i_scan.op;
            r_in_step    <= step_sat[STEP_W-1:0];
            r_in_contact <= i_scan.contact;
        end
    end

    stlt_engine #(
        .MAX_STEPS (MAX_STEPS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (process),
        .i_op      (r_in_op),
        .i_step    (r_in_step),
        .i_contact (r_in_contact),
        .o_result  (eng_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out <= eng_result;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.aim_valid    = r_out.aim_valid;
    assign o_result.aim_position = r_out.aim_position;
    assign o_result.laser_on     = r_out.laser_on;
    assign o_result.sound        = r_out.sound;
    assign o_result.locked       = r_out.locked;

endmodule

>>> sv/stlt_checker.sv
module stlt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic                            i_aim_valid,
    input logic [stlt_pkg::POS_W-1:0]      i_aim_position,
    input logic                            i_laser_on,
    input logic [stlt_pkg::SOUND_W-1:0]    i_sound
);

    // No word leaves the block in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    // An aim always leaves the laser on.
    a_aim_laser: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_aim_valid) |-> i_laser_on)
        else $error("aim issued with laser off");

    // Acquired and restored sounds only come with an aim.
    a_sound_aim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_sound == stlt_pkg::SND_ACQUIRED ||
                         i_sound == stlt_pkg::SND_RESTORED)) |-> i_aim_valid)
        else $error("acquire sound without aim");

    // Contact lost means the laser has just gone off, and no aim is issued.
    a_contact_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_sound == stlt_pkg::SND_CONTACT) |-> (!i_laser_on && !i_aim_valid))
        else $error("contact lost sound with laser on");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_aim_valid) && $stable(i_aim_position) &&
             $stable(i_laser_on) && $stable(i_sound)))
        else $error("stalled result word changed");

endmodule

bind scan_target_lock_tracker stlt_checker u_stlt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_aim_valid    (o_result.aim_valid),
    .i_aim_position (o_result.aim_position),
    .i_laser_on     (o_result.laser_on),
    .i_sound        (o_result.sound)
);
